[hdl/drf_pkg.sv]
// ----------------------------------------------------------------------------
// drf_pkg: shared definitions for the decimating record FIFO
// Request and status codes, register indexes, default sizes and the result
// bundle that travels from the control logic to the output stage.
// ----------------------------------------------------------------------------
package drf_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEPTH_DEFAULT        = 256;
  localparam int RECORD_WIDTH_DEFAULT = 64;

  // Fixed field widths of the channels.
  localparam int PORT_RECORD_W = 64;
  localparam int PENDING_W     = 9;
  localparam int TOTAL_W       = 32;
  localparam int DIV_W         = 16;
  localparam int CAP_FIELD_W   = 9;

  // Configuration port widths.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_CAPTURE = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  // Register indexes, taken from byte address bit 2.
  localparam logic REG_DIVIDER  = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Result fields other than the record word, as registered by the control logic.
  typedef struct packed {
    status_t              status;
    logic                 record_valid;
    logic [PENDING_W-1:0] pending_count;
    logic [TOTAL_W-1:0]   lost_count;
    logic [TOTAL_W-1:0]   stored_count;
  } res_info_t;

endpackage

[hdl/drf_req_if.sv]
// ----------------------------------------------------------------------------
// drf_req_if: request channel
// Valid/ready channel carrying one request beat: request type and record word.
// ----------------------------------------------------------------------------
interface drf_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [drf_pkg::PORT_RECORD_W-1:0] record_in;

  modport source (output valid, output req_type, output record_in, input ready);
  modport sink   (input valid, input req_type, input record_in, output ready);
endinterface

[hdl/drf_res_if.sv]
// ----------------------------------------------------------------------------
// drf_res_if: result channel
// Valid/ready channel carrying one result beat: status, record and counts.
// ----------------------------------------------------------------------------
interface drf_res_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [drf_pkg::PORT_RECORD_W-1:0] record_out;
  logic                              record_valid;
  logic [drf_pkg::PENDING_W-1:0]     pending_count;
  logic [drf_pkg::TOTAL_W-1:0]       lost_count;
  logic [drf_pkg::TOTAL_W-1:0]       stored_count;

  modport source (output valid, output status, output record_out, output record_valid,
                  output pending_count, output lost_count, output stored_count,
                  input ready);
  modport sink   (input valid, input status, input record_out, input record_valid,
                  input pending_count, input lost_count, input stored_count,
                  output ready);
endinterface

[hdl/drf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// drf_cfg_regs: configuration registers
// APB-style register file holding the capture divider and the capacity in use.
// ----------------------------------------------------------------------------
module drf_cfg_regs #(
  parameter int DEPTH = drf_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [drf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [drf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [drf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [drf_pkg::DIV_W-1:0]       divider,
  output logic [((($clog2(DEPTH+1)) > drf_pkg::CAP_FIELD_W) ?
                 $clog2(DEPTH+1) : drf_pkg::CAP_FIELD_W)-1:0] capacity
);

  localparam int CNT_W = ($clog2(DEPTH+1) > drf_pkg::CAP_FIELD_W) ?
                         $clog2(DEPTH+1) : drf_pkg::CAP_FIELD_W;

  logic wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      divider  <= drf_pkg::DIV_W'(1);
      capacity <= CNT_W'(DEPTH);
    end else if (wr_en) begin
      unique case (paddr[2])
        drf_pkg::REG_DIVIDER: begin
          divider <= pwdata[drf_pkg::DIV_W-1:0];
        end
        drf_pkg::REG_CAPACITY: begin
          capacity <= CNT_W'(pwdata[drf_pkg::CAP_FIELD_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (paddr[2])
      drf_pkg::REG_DIVIDER:  prdata = drf_pkg::APB_DATA_W'(divider);
      drf_pkg::REG_CAPACITY: prdata = drf_pkg::APB_DATA_W'(capacity);
      default:               prdata = '0;
    endcase
  end

endmodule

[hdl/drf_store.sv]
// ----------------------------------------------------------------------------
// drf_store: record memory
// Single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module drf_store #(
  parameter int DEPTH        = drf_pkg::DEPTH_DEFAULT,
  parameter int RECORD_WIDTH = drf_pkg::RECORD_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [RECORD_WIDTH-1:0]    wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [RECORD_WIDTH-1:0]    rdata
);

  logic [RECORD_WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/drf_ctrl.sv]
// ----------------------------------------------------------------------------
// drf_ctrl: pointer and counter control
// Decodes each accepted request, updates pointers, fill level, divider phase
// and totals, drives the store ports and registers the result fields.
// ----------------------------------------------------------------------------
module drf_ctrl #(
  parameter int DEPTH = drf_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      req_type,
  input  logic [drf_pkg::DIV_W-1:0]       divider,
  input  logic [((($clog2(DEPTH+1)) > drf_pkg::CAP_FIELD_W) ?
                 $clog2(DEPTH+1) : drf_pkg::CAP_FIELD_W)-1:0] capacity,
  output logic                            we,
  output logic [$clog2(DEPTH)-1:0]        waddr,
  output logic                            re,
  output logic [$clog2(DEPTH)-1:0]        raddr,
  output drf_pkg::res_info_t              info
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = ($clog2(DEPTH+1) > drf_pkg::CAP_FIELD_W) ?
                         $clog2(DEPTH+1) : drf_pkg::CAP_FIELD_W;
  localparam int CMP_W = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;

  logic [PTR_W-1:0]            write_pointer, write_pointer_next;
  logic [PTR_W-1:0]            read_pointer, read_pointer_next;
  logic [CNT_W-1:0]            fill_level, fill_level_next;
  logic [drf_pkg::DIV_W-1:0]   divider_phase, divider_phase_next;
  logic [drf_pkg::TOTAL_W-1:0] stored_total, stored_total_next;
  logic [drf_pkg::TOTAL_W-1:0] lost_total, lost_total_next;

  logic [CNT_W-1:0]            cap_eff;
  logic [drf_pkg::DIV_W-1:0]   phase_inc;
  logic [CMP_W-1:0]            wp_inc, rp_inc;
  logic [PTR_W-1:0]            wp_adv, rp_adv;
  drf_pkg::status_t            status;
  logic                        rec_valid;

  // Clamp the capacity to the range the store supports.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (capacity > CNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = capacity;
    end
  end

  // Pointer advance with wrap at the capacity in use.
  always_comb begin
    wp_inc    = CMP_W'(write_pointer) + CMP_W'(1);
    rp_inc    = CMP_W'(read_pointer) + CMP_W'(1);
    wp_adv    = (wp_inc >= CMP_W'(cap_eff)) ? '0 : wp_inc[PTR_W-1:0];
    rp_adv    = (rp_inc >= CMP_W'(cap_eff)) ? '0 : rp_inc[PTR_W-1:0];
    phase_inc = divider_phase + 1'b1;
  end

  // Request decode and next state.
  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    fill_level_next    = fill_level;
    divider_phase_next = divider_phase;
    stored_total_next  = stored_total;
    lost_total_next    = lost_total;
    status             = drf_pkg::ST_OK;
    rec_valid          = 1'b0;
    we                 = 1'b0;
    re                 = 1'b0;
    if (accept) begin
      unique case (req_type)
        drf_pkg::REQ_CAPTURE: begin
          divider_phase_next = phase_inc;
          if (phase_inc < divider) begin
            status = drf_pkg::ST_SKIPPED;
          end else begin
            divider_phase_next = '0;
            if (fill_level >= cap_eff) begin
              status = drf_pkg::ST_FULL;
              lost_total_next = (lost_total != '1) ? lost_total + 1'b1 : lost_total;
            end else begin
              we                 = 1'b1;
              write_pointer_next = wp_adv;
              fill_level_next    = fill_level + 1'b1;
              stored_total_next  = (stored_total != '1) ? stored_total + 1'b1 : stored_total;
            end
          end
        end
        drf_pkg::REQ_POP: begin
          if (fill_level == '0) begin
            status = drf_pkg::ST_EMPTY;
          end else begin
            re                = 1'b1;
            rec_valid         = 1'b1;
            read_pointer_next = rp_adv;
            fill_level_next   = fill_level - 1'b1;
          end
        end
        drf_pkg::REQ_CLEAR: begin
          write_pointer_next = '0;
          read_pointer_next  = '0;
          fill_level_next    = '0;
          divider_phase_next = '0;
          stored_total_next  = '0;
          lost_total_next    = '0;
        end
        default: begin
          // Unused request type leaves everything as it is.
        end
      endcase
    end
  end

  assign waddr = write_pointer;
  assign raddr = read_pointer;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      fill_level    <= '0;
      divider_phase <= '0;
      stored_total  <= '0;
      lost_total    <= '0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      fill_level    <= fill_level_next;
      divider_phase <= divider_phase_next;
      stored_total  <= stored_total_next;
      lost_total    <= lost_total_next;
    end
  end

  // Result fields, captured with each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      info.status         <= status;
      info.record_valid   <= rec_valid;
      info.pending_count  <= fill_level_next[drf_pkg::PENDING_W-1:0];
      info.lost_count     <= lost_total_next;
      info.stored_count   <= stored_total_next;
    end
  end

endmodule

[hdl/decimating_record_fifo_core.sv]
// ----------------------------------------------------------------------------
// decimating_record_fifo_core: trace FIFO with decimated capture
// Requests arrive on the req channel (capture offer, pop, clear), one result
// beat per request leaves on the res channel with status, popped record and
// the pending, lost and stored counts.
//
// Usage:
//  - Configure the divider register (byte address 0) and the capacity
//    register (byte address 4) over the APB port while the block is idle.
//  - A request beat is accepted when req.valid and req.ready are high. Its
//    result appears on res in the next cycle, held in an output register.
//  - Throughput is one request per cycle unless res stalls: the pointer and
//    counter update and the single store access per request happen in the
//    same cycle, and the store has separate write and registered read ports.
//  - req.ready is high while the output register is empty or being taken,
//    so a stalled receiver holds the result and back-pressures requests.
//  - Reset empties the output register, zeroes pointers, fill level, divider
//    phase and totals, and restores divider 1 and full capacity. The store is
//    not cleared; the user, not the block, must keep unwritten entries unread.
// ----------------------------------------------------------------------------
module decimating_record_fifo_core #(
  parameter int DEPTH        = drf_pkg::DEPTH_DEFAULT,
  parameter int RECORD_WIDTH = drf_pkg::RECORD_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [drf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [drf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [drf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  drf_req_if.sink                        req,
  drf_res_if.source                      res
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = ($clog2(DEPTH+1) > drf_pkg::CAP_FIELD_W) ?
                         $clog2(DEPTH+1) : drf_pkg::CAP_FIELD_W;

  logic                      accept;
  logic                      res_valid;
  logic [drf_pkg::DIV_W-1:0] divider;
  logic [CNT_W-1:0]          capacity;
  logic                      we, re;
  logic [PTR_W-1:0]          waddr, raddr;
  logic [RECORD_WIDTH-1:0]   rdata;
  drf_pkg::res_info_t        info;

  // Configuration registers.
  drf_cfg_regs #(.DEPTH(DEPTH)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .divider (divider),
    .capacity(capacity)
  );

  // Handshake: take a request whenever the output register can be refilled.
  assign req.ready = !res_valid || res.ready;
  assign accept    = req.valid && req.ready;

  // Pointer and counter control.
  drf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req_type(req.req_type),
    .divider (divider),
    .capacity(capacity),
    .we      (we),
    .waddr   (waddr),
    .re      (re),
    .raddr   (raddr),
    .info    (info)
  );

  // Record store.
  drf_store #(.DEPTH(DEPTH), .RECORD_WIDTH(RECORD_WIDTH)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(req.record_in[RECORD_WIDTH-1:0]),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result beat; the record word is zero unless a record was popped.
  assign res.valid          = res_valid;
  assign res.status         = info.status;
  assign res.record_valid   = info.record_valid;
  assign res.record_out     = info.record_valid ? drf_pkg::PORT_RECORD_W'(rdata) : '0;
  assign res.pending_count  = info.pending_count;
  assign res.lost_count     = info.lost_count;
  assign res.stored_count   = info.stored_count;

`ifndef ASSERT_OFF
  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result pending after reset");

  // A popped record always comes with an ok status.
  a_record_ok: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.record_valid |-> res.status == drf_pkg::ST_OK)
    else $error("record delivered with a non-ok status");

  // Without a popped record the record word is zero.
  a_record_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.record_valid |-> res.record_out == '0)
    else $error("record word not zero without a popped record");

  // A clear zeroes the pending count and both totals in its result.
  a_clear_counts: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == drf_pkg::REQ_CLEAR |=>
      res.valid && res.pending_count == '0 && res.lost_count == '0 &&
      res.stored_count == '0)
    else $error("clear did not restart the counts");
`endif

endmodule

[sim/decimating_record_fifo_core_test.sv]
// ----------------------------------------------------------------------------
// decimating_record_fifo_core_test: self-checking bench for the trace FIFO
// Drives capture, pop, clear and no-op requests through the request channel,
// programs the divider and capacity over APB between phases, and checks each
// result beat field by field against an in-bench model of the decimating
// circular store. Both channels idle at random, and the receiver holds off
// for a long stretch once so that the block back-pressures its input.
// ----------------------------------------------------------------------------
module decimating_record_fifo_core_test;

  localparam int FIFO_DEPTH  = drf_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  // Request type with no defined action; the block must leave its state alone.
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct {
    drf_pkg::status_t              status;
    logic [63:0]                   rec_word;
    logic                          record_valid;
    logic [drf_pkg::PENDING_W-1:0] pending;
    logic [drf_pkg::TOTAL_W-1:0]   dropped;
    logic [drf_pkg::TOTAL_W-1:0]   captured;
  } fifo_result_t;

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [drf_pkg::APB_ADDR_W-1:0] paddr;
  logic [drf_pkg::APB_DATA_W-1:0] pwdata;
  logic [drf_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  drf_req_if req_ch ();
  drf_res_if res_ch ();

  decimating_record_fifo_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .res     (res_ch)
  );

  // Model state of the trace FIFO and its registers.
  logic [63:0]                     store_mem [FIFO_DEPTH];
  bit                              store_written [FIFO_DEPTH];
  logic [7:0]                      wr_ptr       = '0;
  logic [7:0]                      rd_ptr       = '0;
  logic [drf_pkg::PENDING_W-1:0]   held_count   = '0;
  logic [drf_pkg::DIV_W-1:0]       offer_phase  = '0;
  logic [drf_pkg::TOTAL_W-1:0]     stored_total = '0;
  logic [drf_pkg::TOTAL_W-1:0]     lost_total   = '0;
  logic [drf_pkg::DIV_W-1:0]       cfg_divider  = 16'd1;
  logic [drf_pkg::CAP_FIELD_W-1:0] cfg_capacity = 9'd256;

  fifo_result_t results_due[$];
  int           mismatch_count = 0;
  int           beat_count     = 0;
  int           cycle_count    = 0;
  bit           idle_on        = 1'b1;
  bit           hold_start     = 1'b0;
  logic         sink_hold;
  int           stall_left;

  // Clock generation.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [drf_pkg::TOTAL_W-1:0] bump_total(
      input logic [drf_pkg::TOTAL_W-1:0] v);
    return (v != '1) ? v + 1'b1 : v;
  endfunction

  function automatic logic [7:0] ring_next(input logic [7:0] idx, input int cap);
    int n;
    n = int'(idx) + 1;
    return (n >= cap) ? 8'd0 : n[7:0];
  endfunction

  // A pop may only be issued when it reads an entry that has been written.
  function automatic bit pop_reads_known();
    return (held_count == 0) || store_written[rd_ptr];
  endfunction

  // Advance the model by one request and return the result it must produce.
  function automatic fifo_result_t trace_fifo_step(input logic [1:0] kind,
                                                   input logic [63:0] word);
    fifo_result_t r;
    int           cap;
    r.status       = drf_pkg::ST_OK;
    r.rec_word     = '0;
    r.record_valid = 1'b0;
    cap = (cfg_capacity == 0) ? 1 :
          ((int'(cfg_capacity) > FIFO_DEPTH) ? FIFO_DEPTH : int'(cfg_capacity));
    case (kind)
      drf_pkg::REQ_CAPTURE: begin
        offer_phase = offer_phase + 1'b1;
        if (offer_phase < cfg_divider) begin
          r.status = drf_pkg::ST_SKIPPED;
        end else begin
          // The phase restarts on every kept offer, stored or dropped.
          offer_phase = '0;
          if (int'(held_count) >= cap) begin
            lost_total = bump_total(lost_total);
            r.status   = drf_pkg::ST_FULL;
          end else begin
            store_mem[wr_ptr]     = word;
            store_written[wr_ptr] = 1'b1;
            wr_ptr       = ring_next(wr_ptr, cap);
            held_count   = held_count + 1'b1;
            stored_total = bump_total(stored_total);
          end
        end
      end
      drf_pkg::REQ_POP: begin
        if (held_count == 0) begin
          r.status = drf_pkg::ST_EMPTY;
        end else begin
          r.rec_word     = store_mem[rd_ptr];
          r.record_valid = 1'b1;
          rd_ptr     = ring_next(rd_ptr, cap);
          held_count = held_count - 1'b1;
        end
      end
      drf_pkg::REQ_CLEAR: begin
        // Store contents survive a clear; only pointers and counters restart.
        wr_ptr       = '0;
        rd_ptr       = '0;
        held_count   = '0;
        offer_phase  = '0;
        stored_total = '0;
        lost_total   = '0;
      end
      default: begin
      end
    endcase
    r.pending  = held_count;
    r.dropped  = lost_total;
    r.captured = stored_total;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR result beat %0d: %s is 0x%0h, expected 0x%0h", beat_count, what,
             got, want);
    mismatch_count++;
  endtask

  // Send one request beat and queue the result it must produce.
  task automatic send_request(input logic [1:0] kind, input logic [63:0] word);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.record_in <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    results_due.push_back(trace_fifo_step(kind, word));
  endtask

  // Stop offering and wait for every outstanding result beat.
  task automatic wait_until_idle();
    req_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write, issued only once the block has gone idle.
  task automatic write_register(input logic reg_sel, input logic [31:0] value);
    wait_until_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == drf_pkg::REG_DIVIDER) begin
      cfg_divider = value[drf_pkg::DIV_W-1:0];
    end else begin
      cfg_capacity = value[drf_pkg::CAP_FIELD_W-1:0];
    end
  endtask

  // Receiver ready: random stall bursts, or a long hold.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (sink_hold) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Long receiver hold, counted here in cycles.
  initial begin : sink_hold_flow
    int held;
    sink_hold = 1'b0;
    forever begin
      wait (hold_start);
      hold_start = 1'b0;
      @(posedge clk);
      sink_hold <= 1'b1;
      held = 0;
      while (held < HOLD_CYCLES) begin
        @(posedge clk);
        held++;
      end
      sink_hold <= 1'b0;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      beat_count++;
      if (results_due.size() == 0) begin
        report_mismatch("unexpected beat, status", 64'(res_ch.status), '0);
      end else begin
        want = results_due.pop_front();
        if (res_ch.status !== want.status)
          report_mismatch("status", 64'(res_ch.status), 64'(want.status));
        if (res_ch.record_out !== want.rec_word)
          report_mismatch("record_out", res_ch.record_out, want.rec_word);
        if (res_ch.record_valid !== want.record_valid)
          report_mismatch("record_valid", 64'(res_ch.record_valid),
                          64'(want.record_valid));
        if (res_ch.pending_count !== want.pending)
          report_mismatch("pending_count", 64'(res_ch.pending_count), 64'(want.pending));
        if (res_ch.lost_count !== want.dropped)
          report_mismatch("lost_count", 64'(res_ch.lost_count), 64'(want.dropped));
        if (res_ch.stored_count !== want.captured)
          report_mismatch("stored_count", 64'(res_ch.stored_count), 64'(want.captured));
      end
    end
  end

  // Reset defaults: empty pops, extreme record words, no-op request and clear.
  task automatic test_basic_requests();
    send_request(drf_pkg::REQ_POP, '0);
    send_request(drf_pkg::REQ_CAPTURE, '1);
    send_request(drf_pkg::REQ_CAPTURE, '0);
    send_request(drf_pkg::REQ_CAPTURE, 64'hA5A5_5A5A_0F0F_F0F0);
    send_request(REQ_NONE, 64'hDEAD_BEEF_0123_4567);
    send_request(drf_pkg::REQ_POP, '1);
    send_request(drf_pkg::REQ_POP, '0);
    send_request(drf_pkg::REQ_POP, '0);
    send_request(drf_pkg::REQ_POP, '0);
    send_request(drf_pkg::REQ_CAPTURE, 64'h8000_0000_0000_0001);
    send_request(drf_pkg::REQ_CLEAR, '1);
    send_request(drf_pkg::REQ_POP, '0);
    send_request(drf_pkg::REQ_CAPTURE, 64'h7FFF_FFFF_FFFF_FFFE);
    send_request(drf_pkg::REQ_POP, '0);
  endtask

  // Decimation: a regular divider, zero, a lowered divider and the maximum.
  task automatic test_divider_settings();
    send_request(drf_pkg::REQ_CLEAR, '0);
    write_register(drf_pkg::REG_DIVIDER, 32'd3);
    repeat (4) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    write_register(drf_pkg::REG_DIVIDER, 32'd0);
    repeat (2) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    write_register(drf_pkg::REG_DIVIDER, 32'd5);
    repeat (3) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    // The phase now sits above the new divider, so the next offer is kept.
    write_register(drf_pkg::REG_DIVIDER, 32'd2);
    send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    write_register(drf_pkg::REG_DIVIDER, 32'd65535);
    repeat (3) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    write_register(drf_pkg::REG_DIVIDER, 32'd1);
    send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
  endtask

  // Capacity limits: one entry, zero, above the depth, and lowered while held.
  task automatic test_capacity_settings();
    write_register(drf_pkg::REG_CAPACITY, 32'd1);
    send_request(drf_pkg::REQ_CLEAR, '0);
    send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    send_request(drf_pkg::REQ_POP, '0);
    send_request(drf_pkg::REQ_POP, '0);
    // A kept offer that meets a full store still restarts the phase.
    write_register(drf_pkg::REG_DIVIDER, 32'd2);
    repeat (5) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    send_request(drf_pkg::REQ_POP, '0);
    write_register(drf_pkg::REG_DIVIDER, 32'd1);
    write_register(drf_pkg::REG_CAPACITY, 32'd0);
    send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    send_request(drf_pkg::REQ_POP, '0);
    write_register(drf_pkg::REG_CAPACITY, 32'd300);
    repeat (3) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    repeat (3) send_request(drf_pkg::REQ_POP, '0);
    write_register(drf_pkg::REG_CAPACITY, 32'd511);
    repeat (2) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    send_request(drf_pkg::REQ_POP, '0);
    // Shrink the store while records are held; pointers wrap on next advance.
    write_register(drf_pkg::REG_CAPACITY, 32'd256);
    send_request(drf_pkg::REQ_CLEAR, '0);
    repeat (6) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    repeat (4) send_request(drf_pkg::REQ_POP, '0);
    write_register(drf_pkg::REG_CAPACITY, 32'd3);
    repeat (2) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    repeat (4) send_request(drf_pkg::REQ_POP, '0);
  endtask

  // Fill the whole store while the receiver holds off, overflow it, drain it.
  task automatic test_full_store_backpressure();
    write_register(drf_pkg::REG_CAPACITY, 32'd256);
    send_request(drf_pkg::REQ_CLEAR, '0);
    hold_start = 1'b1;
    repeat (FIFO_DEPTH + 4) send_request(drf_pkg::REQ_CAPTURE, {$urandom, $urandom});
    repeat (FIFO_DEPTH + 2) send_request(drf_pkg::REQ_POP, '0);
  endtask

  // Random request mix over several register settings.
  task automatic test_random_mix();
    int          div_plan [7] = '{1, 0, 3, 2, 1, 4, 1};
    int          cap_plan [7] = '{256, 4, 1, 0, 300, 12, 511};
    logic [1:0]  kind;
    logic [31:0] junk;
    int          pick;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) begin
        idle_on = 1'b0;
      end
      // Upper register bits carry junk that the block must ignore.
      junk = $urandom;
      write_register(drf_pkg::REG_DIVIDER, (junk & 32'hFFFF_0000) | 32'(div_plan[ph]));
      junk = $urandom;
      write_register(drf_pkg::REG_CAPACITY, (junk & 32'hFFFF_FE00) | 32'(cap_plan[ph]));
      for (int n = 0; n < 16; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          kind = drf_pkg::REQ_CAPTURE;
        end else if (pick < 90) begin
          kind = drf_pkg::REQ_POP;
        end else if (pick < 95) begin
          kind = drf_pkg::REQ_CLEAR;
        end else begin
          kind = REQ_NONE;
        end
        if (kind == drf_pkg::REQ_POP && !pop_reads_known()) begin
          kind = drf_pkg::REQ_CAPTURE;
        end
        send_request(kind, {$urandom, $urandom});
      end
    end
  endtask

  initial begin : main_flow
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = drf_pkg::REQ_CAPTURE;
    req_ch.record_in = '0;
    res_ch.ready     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_requests();
    test_divider_settings();
    test_capacity_settings();
    test_full_store_backpressure();
    test_random_mix();

    wait_until_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
